// ===== hw/rtl/linear_interp_resampler_assert.svh =====
// Assertion macros for the resampler RTL.
// LIR_ASSERT is disabled during reset, LIR_ASSERT_RST also checks in reset.
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define LIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LIR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LIR_ASSERT(lbl, prop, msg)
`define LIR_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/lir_pkg.sv =====
package lir_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int FRAC_BITS    = 16;
  localparam int LANES        = 8;
  localparam int SAMPLE_W     = 16;
  localparam int STEP_W       = 19;
  localparam int PHASE_W      = 19;
  localparam int CHAN_W       = 4;
  localparam int MAX_RESULTS  = 16;
  localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PROD_W       = SAMPLE_W + FRAC_BITS + 2;

  localparam logic [PHASE_W:0]     ONE_PHASE  = (PHASE_W + 1)'(1 << FRAC_BITS);
  localparam logic [RES_CNT_W-1:0] RES_LIMIT  = RES_CNT_W'(MAX_RESULTS);
  localparam logic [RES_CNT_W-1:0] RES_LAST   = RES_CNT_W'(MAX_RESULTS - 1);
  localparam logic [STEP_W-1:0]    STEP_RST   = STEP_W'(65536);
  localparam logic [CHAN_W-1:0]    CHAN_RST   = CHAN_W'(2);
  localparam logic                 BYPASS_RST = 1'b1;

  typedef enum logic [ADDR_W-3:0] {
    REG_STEP   = 2'd0,
    REG_CHANS  = 2'd1,
    REG_BYPASS = 2'd2
  } reg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [CHAN_W-1:0] chans;
    logic              bypass;
  } cfg_t;

  typedef struct packed {
    logic                      bypass;
    logic [LANES-1:0]          mask;
    logic [LANES-1:0][SAMPLE_W-1:0] smp;
  } job_t;

  function automatic logic [LANES-1:0] lane_mask(logic [CHAN_W-1:0] n);
    logic [LANES-1:0] m;
    for (int i = 0; i < LANES; i++) begin
      m[i] = (i < int'(n)) && (i < MAX_CHANNELS);
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/lir_if.sv =====
interface lir_in_if;
  logic valid;
  logic ready;
  logic signed [lir_pkg::SAMPLE_W-1:0] sample_0;
  logic signed [lir_pkg::SAMPLE_W-1:0] sample_1;
  logic signed [lir_pkg::SAMPLE_W-1:0] sample_2;
  logic signed [lir_pkg::SAMPLE_W-1:0] sample_3;
  logic signed [lir_pkg::SAMPLE_W-1:0] sample_4;
  logic signed [lir_pkg::SAMPLE_W-1:0] sample_5;
  logic signed [lir_pkg::SAMPLE_W-1:0] sample_6;
  logic signed [lir_pkg::SAMPLE_W-1:0] sample_7;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    output ready
  );
endinterface

interface lir_out_if;
  logic valid;
  logic ready;
  logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_0;
  logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_1;
  logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_2;
  logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_3;
  logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_4;
  logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_5;
  logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_6;
  logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_7;
  logic last_of_run;

  modport source (
    output valid, out_sample_0, out_sample_1, out_sample_2, out_sample_3,
           out_sample_4, out_sample_5, out_sample_6, out_sample_7, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, out_sample_0, out_sample_1, out_sample_2, out_sample_3,
           out_sample_4, out_sample_5, out_sample_6, out_sample_7, last_of_run,
    output ready
  );
endinterface

// ===== hw/rtl/lir_cfg.sv =====
module lir_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lir_pkg::ADDR_W-1:0]   paddr,
  input  logic [lir_pkg::DATA_W-1:0]   pwdata,
  output logic [lir_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output lir_pkg::cfg_t                cfg
);

  lir_pkg::cfg_t    cfg_r;
  lir_pkg::cfg_t    cfg_nxt;
  lir_pkg::reg_idx_t idx;
  logic             wr;

  assign idx    = lir_pkg::reg_idx_t'(paddr[lir_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        lir_pkg::REG_STEP:   cfg_nxt.step   = pwdata[lir_pkg::STEP_W-1:0];
        lir_pkg::REG_CHANS:  cfg_nxt.chans  = pwdata[lir_pkg::CHAN_W-1:0];
        lir_pkg::REG_BYPASS: cfg_nxt.bypass = pwdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lir_pkg::REG_STEP:   prdata = lir_pkg::DATA_W'(cfg_r.step);
      lir_pkg::REG_CHANS:  prdata = lir_pkg::DATA_W'(cfg_r.chans);
      lir_pkg::REG_BYPASS: prdata = lir_pkg::DATA_W'(cfg_r.bypass);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step   <= lir_pkg::STEP_RST;
      cfg_r.chans  <= lir_pkg::CHAN_RST;
      cfg_r.bypass <= lir_pkg::BYPASS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hw/rtl/lir_front.sv =====
module lir_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lir_pkg::CHAN_W-1:0] chans,
  input  logic                       bypass,
  lir_in_if.sink                     in_ch,
  output lir_pkg::job_t              job,
  output logic                       job_valid,
  input  logic                       job_ready
);

  lir_pkg::job_t q_r [lir_pkg::QUEUE_DEPTH];
  lir_pkg::job_t in_job;

  logic [lir_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lir_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lir_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       push;
  logic                       pop;

  // classify: capture mode and active lanes with the frame
  always_comb begin
    in_job.bypass = bypass;
    in_job.mask   = lir_pkg::lane_mask(chans);
    in_job.smp[0] = in_ch.sample_0;
    in_job.smp[1] = in_ch.sample_1;
    in_job.smp[2] = in_ch.sample_2;
    in_job.smp[3] = in_ch.sample_3;
    in_job.smp[4] = in_ch.sample_4;
    in_job.smp[5] = in_ch.sample_5;
    in_job.smp[6] = in_ch.sample_6;
    in_job.smp[7] = in_ch.sample_7;
  end

  assign in_ch.ready = (cnt_r != lir_pkg::QCNT_W'(lir_pkg::QUEUE_DEPTH));
  assign job_valid   = (cnt_r != '0);
  assign job         = q_r[rd_ptr_r];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = job_valid && job_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == lir_pkg::QPTR_W'(lir_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_r + lir_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == lir_pkg::QPTR_W'(lir_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_r + lir_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + lir_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - lir_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/lir_back.sv =====
`include "linear_interp_resampler_assert.svh"

module lir_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lir_pkg::STEP_W-1:0] step,
  input  lir_pkg::job_t              job,
  input  logic                       job_valid,
  output logic                       job_ready,
  lir_out_if.source                  out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef logic signed [lir_pkg::SAMPLE_W:0] wide_t;

  function automatic lir_pkg::sample_t sat_add(lir_pkg::sample_t b, wide_t o);
    logic [lir_pkg::SAMPLE_W+1:0] s;
    logic [2:0]                   top;
    s   = {{2{b[lir_pkg::SAMPLE_W-1]}}, b} + {o[lir_pkg::SAMPLE_W], o};
    top = s[lir_pkg::SAMPLE_W+1:lir_pkg::SAMPLE_W-1];
    if ((&top) || !(|top)) begin
      return s[lir_pkg::SAMPLE_W-1:0];
    end
    return s[lir_pkg::SAMPLE_W+1] ? {1'b1, {(lir_pkg::SAMPLE_W-1){1'b0}}}
                                  : {1'b0, {(lir_pkg::SAMPLE_W-1){1'b1}}};
  endfunction

  state_t                          state_r, state_nxt;
  lir_pkg::job_t                   cur_r, cur_nxt;
  lir_pkg::sample_t [lir_pkg::LANES-1:0] prev_r, prev_nxt;
  wide_t                           diff_r [lir_pkg::LANES];
  wide_t                           diff_nxt [lir_pkg::LANES];
  logic                            have_prev_r, have_prev_nxt;
  logic [lir_pkg::PHASE_W-1:0]     phase_r, phase_nxt;
  logic [lir_pkg::RES_CNT_W-1:0]   cnt_r, cnt_nxt;

  logic                            s1_valid_r, s1_valid_nxt;
  lir_pkg::sample_t                s1_base_r [lir_pkg::LANES];
  lir_pkg::sample_t                s1_base_nxt [lir_pkg::LANES];
  wide_t                           s1_ofs_r [lir_pkg::LANES];
  wide_t                           s1_ofs_nxt [lir_pkg::LANES];
  logic                            s1_last_r, s1_last_nxt;

  logic                            out_valid_r, out_valid_nxt;
  lir_pkg::sample_t                out_smp_r [lir_pkg::LANES];
  lir_pkg::sample_t                out_smp_nxt [lir_pkg::LANES];
  logic                            out_last_r, out_last_nxt;

  logic signed [lir_pkg::PROD_W-1:0] prod [lir_pkg::LANES];
  logic [lir_pkg::PHASE_W:0]       phase_sum;
  logic [lir_pkg::PHASE_W:0]       phase_src;
  logic                            o_adv;
  logic                            s1_free;
  logic                            phase_lt_one;
  logic                            more;
  logic                            last_job;
  logic                            issue;
  logic                            finish;
  logic                            seed;

  assign o_adv        = !out_valid_r || out_ch.ready;
  assign s1_free      = !s1_valid_r || o_adv;
  assign job_ready    = (state_r == ST_IDLE);
  assign seed         = !job.bypass && !have_prev_r;
  assign phase_lt_one = {1'b0, phase_r} < lir_pkg::ONE_PHASE;
  assign more         = phase_lt_one && (cnt_r < lir_pkg::RES_LIMIT);
  assign phase_sum    = {1'b0, phase_r} + {1'b0, step};
  assign last_job     = cur_r.bypass || (phase_sum >= lir_pkg::ONE_PHASE)
                     || (cnt_r == lir_pkg::RES_LAST);
  assign issue        = (state_r == ST_RUN) && s1_free && (cur_r.bypass || more);
  assign finish       = (state_r == ST_RUN)
                     && (cur_r.bypass ? s1_free : (!more || (s1_free && last_job)));
  assign phase_src    = issue ? phase_sum : {1'b0, phase_r};

  // sequencer: one blended frame per cycle while the product stage can take it
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    diff_nxt      = diff_r;
    have_prev_nxt = have_prev_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          cur_nxt   = job;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
          if (seed) begin
            have_prev_nxt = 1'b1;
          end
          for (int i = 0; i < lir_pkg::LANES; i++) begin
            if (seed && job.mask[i]) begin
              prev_nxt[i] = job.smp[i];
            end
            diff_nxt[i] = seed ? '0
                        : {job.smp[i][lir_pkg::SAMPLE_W-1], job.smp[i]}
                        - {prev_r[i][lir_pkg::SAMPLE_W-1], prev_r[i]};
          end
        end
      end
      ST_RUN: begin
        if (issue) begin
          cnt_nxt = cnt_r + lir_pkg::RES_CNT_W'(1);
          if (!cur_r.bypass) begin
            phase_nxt = phase_sum[lir_pkg::PHASE_W-1:0];
          end
        end
        if (finish) begin
          state_nxt     = ST_IDLE;
          have_prev_nxt = 1'b1;
          for (int i = 0; i < lir_pkg::LANES; i++) begin
            if (cur_r.mask[i]) begin
              prev_nxt[i] = cur_r.smp[i];
            end
          end
          if (!cur_r.bypass) begin
            phase_nxt = (phase_src >= lir_pkg::ONE_PHASE)
                      ? lir_pkg::PHASE_W'(phase_src - lir_pkg::ONE_PHASE) : '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // product stage: base p, offset ((c - p) * frac) >>> FRAC_BITS (bypass: c and 0; inactive lanes: 0)
  always_comb begin
    s1_valid_nxt = s1_free ? issue : s1_valid_r;
    s1_last_nxt  = issue ? last_job : s1_last_r;
    for (int i = 0; i < lir_pkg::LANES; i++) begin
      prod[i] = diff_r[i] * $signed({1'b0, phase_r[lir_pkg::FRAC_BITS-1:0]});
      s1_base_nxt[i] = s1_base_r[i];
      s1_ofs_nxt[i]  = s1_ofs_r[i];
      if (issue) begin
        if (!cur_r.mask[i]) begin
          s1_base_nxt[i] = '0;
          s1_ofs_nxt[i]  = '0;
        end else if (cur_r.bypass) begin
          s1_base_nxt[i] = cur_r.smp[i];
          s1_ofs_nxt[i]  = '0;
        end else begin
          s1_base_nxt[i] = prev_r[i];
          s1_ofs_nxt[i]  = prod[i][lir_pkg::SAMPLE_W+lir_pkg::FRAC_BITS:lir_pkg::FRAC_BITS];
        end
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = o_adv ? s1_valid_r : out_valid_r;
    out_last_nxt  = (o_adv && s1_valid_r) ? s1_last_r : out_last_r;
    for (int i = 0; i < lir_pkg::LANES; i++) begin
      out_smp_nxt[i] = (o_adv && s1_valid_r) ? sat_add(s1_base_r[i], s1_ofs_r[i])
                                             : out_smp_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      phase_r     <= '0;
      cnt_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    diff_r     <= diff_nxt;
    s1_base_r  <= s1_base_nxt;
    s1_ofs_r   <= s1_ofs_nxt;
    s1_last_r  <= s1_last_nxt;
    out_smp_r  <= out_smp_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_sample_0 = out_smp_r[0];
  assign out_ch.out_sample_1 = out_smp_r[1];
  assign out_ch.out_sample_2 = out_smp_r[2];
  assign out_ch.out_sample_3 = out_smp_r[3];
  assign out_ch.out_sample_4 = out_smp_r[4];
  assign out_ch.out_sample_5 = out_smp_r[5];
  assign out_ch.out_sample_6 = out_smp_r[6];
  assign out_ch.out_sample_7 = out_smp_r[7];
  assign out_ch.last_of_run  = out_last_r;

  `LIR_ASSERT(a_run_bounded, state_r == ST_RUN |-> cnt_r < lir_pkg::RES_LIMIT, "run overflow")
  `LIR_ASSERT(a_last_ends_run, issue && last_job |=> state_r == ST_IDLE, "last item not final")
  `LIR_ASSERT(a_s1_hold, s1_valid_r && !o_adv |=> s1_valid_r && $stable(s1_last_r), "s1 lost")
  `LIR_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid_r && !s1_valid_r && state_r == ST_IDLE, "reset")

endmodule

// ===== hw/rtl/linear_interp_resampler.sv =====
// Linear-interpolation sample-rate converter for up to eight 16-bit PCM lanes.
// Each input item is one frame; an interpolating frame yields 0 to 16 output
// frames (last_of_run marks the final one), a bypass frame yields one copy.
// The back end loads a frame and then issues one blended output frame per
// cycle while the product register can advance; it takes the next frame
// only after the current one has finished. Results leave through a product
// register and an output register. A two-entry queue sits in front, so
// input items are taken while the back end works or stalls, until it fills.
// Registers over APB: 0x0 step_increment (unsigned Q3.16), 0x4 channel_count, 0x8 bypass.
module linear_interp_resampler (
  input  logic                       clk,
  input  logic                       rst_n,
  lir_in_if.sink                     in_ch,
  lir_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lir_pkg::ADDR_W-1:0] paddr,
  input  logic [lir_pkg::DATA_W-1:0] pwdata,
  output logic [lir_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  lir_pkg::cfg_t cfg;
  lir_pkg::job_t job;
  logic          job_valid;
  logic          job_ready;

  lir_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lir_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .chans     (cfg.chans),
    .bypass    (cfg.bypass),
    .in_ch     (in_ch),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready)
  );

  lir_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (cfg.step),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [lir_pkg::LANES-1:0][lir_pkg::SAMPLE_W-1:0] frame_t;
  typedef struct packed {
    frame_t lanes;
    logic   last;
  } out_frame_t;

  localparam int unsigned UNIT_PHASE = 1 << lir_pkg::FRAC_BITS;
  localparam int HOLD_OFF = 300;
  localparam int SETTLE = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [lir_pkg::ADDR_W-1:0] paddr;
  logic [lir_pkg::DATA_W-1:0] pwdata, prdata;

  lir_in_if  in_bus();
  lir_out_if out_bus();

  linear_interp_resampler uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow registers and resampler state
  int unsigned rate_step = 65536;
  int unsigned lane_count = 2;
  bit          pass_through = 1'b1;
  int unsigned phase_acc = 0;
  frame_t      prev_frame = '0;
  bit          primed = 1'b0;

  frame_t     pending_frames[$];
  out_frame_t expected_frames[$];

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  bit idle_on = 1'b0;
  int src_gap, sink_gap, hold_left;
  int stalls_asked = 0;
  int stalls_done;
  int mismatches = 0;
  int frames_in = 0;
  int frames_out = 0;
  int settings_seen = 0;

  function automatic void report(string msg);
    mismatches++;
    $display("%0t: %s", $time, msg);
  endfunction

  function automatic void resample_frame(frame_t cur);
    int unsigned n, frac;
    int emitted;
    longint mix;
    out_frame_t r;
    n = (lane_count > lir_pkg::LANES) ? lir_pkg::LANES : lane_count;
    if (n > lir_pkg::MAX_CHANNELS) n = lir_pkg::MAX_CHANNELS;
    if (pass_through) begin
      for (int c = 0; c < lir_pkg::LANES; c++) begin
        r.lanes[c] = (c < n) ? cur[c] : '0;
        if (c < n) prev_frame[c] = cur[c];
      end
      r.last = 1'b1;
      expected_frames.push_back(r);
      primed = 1'b1;
      return;
    end
    if (!primed) begin
      for (int c = 0; c < n; c++) prev_frame[c] = cur[c];
      primed = 1'b1;
    end
    emitted = 0;
    while (phase_acc < UNIT_PHASE && emitted < lir_pkg::MAX_RESULTS) begin
      frac = phase_acc & (UNIT_PHASE - 1);
      for (int c = 0; c < lir_pkg::LANES; c++) begin
        if (c < n) begin
          mix = longint'($signed(prev_frame[c])) * longint'(UNIT_PHASE - frac)
              + longint'($signed(cur[c])) * longint'(frac);
          mix = mix >>> lir_pkg::FRAC_BITS;
          if (mix > 32767) mix = 32767;
          else if (mix < -32768) mix = -32768;
          r.lanes[c] = mix[lir_pkg::SAMPLE_W-1:0];
        end else begin
          r.lanes[c] = '0;
        end
      end
      r.last = 1'b0;
      expected_frames.push_back(r);
      emitted++;
      phase_acc += rate_step;
    end
    if (emitted > 0) expected_frames[expected_frames.size()-1].last = 1'b1;
    if (phase_acc >= UNIT_PHASE) phase_acc -= UNIT_PHASE;
    else phase_acc = 0;
    for (int c = 0; c < n; c++) prev_frame[c] = cur[c];
  endfunction

  // predict on input, check on output
  always @(posedge clk) begin : scoreboard
    frame_t f;
    out_frame_t got, want;
    in_fire <= rst_n && in_bus.valid && in_bus.ready;
    out_fire <= rst_n && out_bus.valid && out_bus.ready;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      f = {in_bus.sample_7, in_bus.sample_6, in_bus.sample_5, in_bus.sample_4,
           in_bus.sample_3, in_bus.sample_2, in_bus.sample_1, in_bus.sample_0};
      resample_frame(f);
      frames_in++;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.lanes = {out_bus.out_sample_7, out_bus.out_sample_6, out_bus.out_sample_5,
                   out_bus.out_sample_4, out_bus.out_sample_3, out_bus.out_sample_2,
                   out_bus.out_sample_1, out_bus.out_sample_0};
      got.last = out_bus.last_of_run;
      if (expected_frames.size() == 0) begin
        report($sformatf("output frame: expected none, got %h last %0b",
                         got.lanes, got.last));
      end else begin
        want = expected_frames.pop_front();
        frames_out++;
        for (int c = 0; c < lir_pkg::LANES; c++)
          if (got.lanes[c] !== want.lanes[c])
            report($sformatf("lane %0d: expected %0d, got %0d", c,
                             $signed(want.lanes[c]), $signed(got.lanes[c])));
        if (got.last !== want.last)
          report($sformatf("last_of_run: expected %0b, got %0b", want.last, got.last));
      end
    end
  end

  always @(negedge clk) begin : feeder
    frame_t f;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.sample_0 <= '0;
      in_bus.sample_1 <= '0;
      in_bus.sample_2 <= '0;
      in_bus.sample_3 <= '0;
      in_bus.sample_4 <= '0;
      in_bus.sample_5 <= '0;
      in_bus.sample_6 <= '0;
      in_bus.sample_7 <= '0;
      src_gap <= 0;
    end else if (!in_bus.valid || in_fire) begin
      if (src_gap > 0) begin
        in_bus.valid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (pending_frames.size() > 0) begin
        f = pending_frames.pop_front();
        in_bus.sample_0 <= f[0];
        in_bus.sample_1 <= f[1];
        in_bus.sample_2 <= f[2];
        in_bus.sample_3 <= f[3];
        in_bus.sample_4 <= f[4];
        in_bus.sample_5 <= f[5];
        in_bus.sample_6 <= f[6];
        in_bus.sample_7 <= f[7];
        in_bus.valid <= 1'b1;
        src_gap <= idle_on ? $urandom_range(0, 3) : 0;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    int g;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      sink_gap <= 0;
      hold_left <= 0;
      stalls_done <= 0;
    end else if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stalls_done != stalls_asked) begin
      out_bus.ready <= 1'b0;
      hold_left <= HOLD_OFF;
      stalls_done <= stalls_done + 1;
    end else if (out_fire) begin
      g = idle_on ? $urandom_range(0, 3) : 0;
      out_bus.ready <= (g == 0);
      sink_gap <= (g == 0) ? 0 : g - 1;
    end else if (!out_bus.ready) begin
      if (sink_gap > 0) sink_gap <= sink_gap - 1;
      else out_bus.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (psel && penable)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic cfg_write(input lir_pkg::reg_idx_t idx, input int unsigned val);
    logic [lir_pkg::DATA_W-1:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= lir_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      lir_pkg::REG_STEP:  rate_step = val;
      lir_pkg::REG_CHANS: lane_count = val;
      default:            pass_through = val[0];
    endcase
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== lir_pkg::DATA_W'(val))
      report($sformatf("readback of %s: expected %0d, got %0d", idx.name(), val, got));
  endtask

  task automatic configure(int unsigned step, int unsigned lanes, bit byp);
    cfg_write(lir_pkg::REG_STEP, step);
    cfg_write(lir_pkg::REG_CHANS, lanes);
    cfg_write(lir_pkg::REG_BYPASS, byp);
    settings_seen++;
  endtask

  // checked at the rising edge, where the driven signals are settled
  task automatic settle();
    while (pending_frames.size() != 0 || in_bus.valid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic frame_t fill(logic [lir_pkg::SAMPLE_W-1:0] v);
    frame_t f;
    for (int c = 0; c < lir_pkg::LANES; c++) f[c] = v;
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    for (int c = 0; c < lir_pkg::LANES; c++) begin
      case ($urandom_range(0, 7))
        0:       f[c] = 16'h7fff;
        1:       f[c] = 16'h8000;
        default: f[c] = 16'($urandom);
      endcase
    end
    return f;
  endfunction

  initial begin : stimulus
    int unsigned step, lanes;
    bit byp;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // first frame seeds history, reset step and lane count
    cfg_write(lir_pkg::REG_BYPASS, 0);
    settings_seen++;
    pending_frames.push_back(fill(16'h7fff));
    pending_frames.push_back(fill(16'h8000));
    pending_frames.push_back(fill(16'h0001));
    settle();

    // half step between full-scale opposites
    configure(32768, 8, 0);
    pending_frames.push_back(fill(16'h8000));
    pending_frames.push_back(fill(16'h7fff));
    pending_frames.push_back(fill(16'hffff));
    settle();

    // zero step hits the per-item result cap, lane count clamps
    configure(0, 15, 0);
    repeat (2) pending_frames.push_back(random_frame());
    settle();

    // largest step: phase stays above one for several items
    configure(524287, 8, 0);
    repeat (4) pending_frames.push_back(random_frame());
    settle();

    configure(4096, 0, 0);
    repeat (2) pending_frames.push_back(random_frame());
    settle();

    configure(4096, 1, 0);
    pending_frames.push_back(fill(16'h8000));
    settle();

    configure(262144, 8, 1);
    pending_frames.push_back(fill(16'h7fff));
    pending_frames.push_back(fill(16'h8000));
    pending_frames.push_back(random_frame());
    settle();

    // back to interpolation keeps phase and history
    cfg_write(lir_pkg::REG_BYPASS, 0);
    settings_seen++;
    repeat (2) pending_frames.push_back(random_frame());
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       step = 0;
        1:       step = 4096;
        2:       step = 262144;
        3:       step = 524287;
        4:       step = $urandom_range(0, 524287);
        default: step = $urandom_range(4096, 262144);
      endcase
      lanes = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      byp = ($urandom_range(0, 4) == 0);
      if (p == 2) begin
        step = 16384;
        byp = 1'b0;
      end
      configure(step, lanes, byp);
      idle_on = ($urandom_range(0, 3) != 0);
      if (p == 2) stalls_asked++;
      repeat (PHASE_ITEMS) pending_frames.push_back(random_frame());
      settle();
    end

    if (expected_frames.size() != 0)
      report($sformatf("pending frames: expected 0, got %0d", expected_frames.size()));
    $display("%0d frames in, %0d frames out checked across %0d register settings",
             frames_in, frames_out, settings_seen);
    $display("bypass, zero and max step, lane counts 0..15, long output stall covered");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
